[design/rau_pkg.sv]
`default_nettype none

package rau_pkg;

  localparam int OPERAND_W = 16;
  localparam int NUM_W     = 2 * OPERAND_W + 1;
  localparam int DEN_W     = 2 * OPERAND_W;
  localparam int MAG_W     = 2 * OPERAND_W;
  localparam int SHIFT_W   = $clog2(MAG_W + 1);
  localparam int CNT_W     = $clog2(MAG_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // unreduced fraction handed from the front end to the reducer
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    fixed;
  } frac_t;

endpackage

`default_nettype wire

[design/rau_front.sv]
`default_nettype none

module rau_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             in_command,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]   in_a_num,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]   in_a_den,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]   in_b_num,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]   in_b_den,
  output logic                                        push_valid,
  input  wire logic                                   push_ready,
  output rau_pkg::frac_t                              push_data
);

  logic signed [rau_pkg::OPERAND_W-1:0] a_den_fix;
  logic signed [rau_pkg::OPERAND_W-1:0] b_den_fix;
  logic                                 in_fix;
  logic                                 accept;

  logic                                 vld_r;
  rau_pkg::cmd_t                        cmd_r;
  logic                                 fix_r;
  logic signed [rau_pkg::DEN_W-1:0]     p_ad_r;
  logic signed [rau_pkg::DEN_W-1:0]     p_bc_r;
  logic signed [rau_pkg::DEN_W-1:0]     p_ac_r;
  logic signed [rau_pkg::DEN_W-1:0]     p_bd_r;

  logic signed [rau_pkg::NUM_W-1:0]     ad_x;
  logic signed [rau_pkg::NUM_W-1:0]     bc_x;
  logic signed [rau_pkg::NUM_W-1:0]     ac_x;
  logic signed [rau_pkg::NUM_W-1:0]     num;
  logic signed [rau_pkg::DEN_W-1:0]     den;
  logic                                 den_zero;

  // zero denominators count as one
  assign a_den_fix = (in_a_den == '0) ? rau_pkg::OPERAND_W'(1) : in_a_den;
  assign b_den_fix = (in_b_den == '0) ? rau_pkg::OPERAND_W'(1) : in_b_den;
  assign in_fix    = (in_a_den == '0) || (in_b_den == '0);

  assign in_ready = !vld_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= rau_pkg::cmd_t'(in_command);
      fix_r  <= in_fix;
      p_ad_r <= rau_pkg::DEN_W'(in_a_num) * rau_pkg::DEN_W'(b_den_fix);
      p_bc_r <= rau_pkg::DEN_W'(a_den_fix) * rau_pkg::DEN_W'(in_b_num);
      p_ac_r <= rau_pkg::DEN_W'(in_a_num) * rau_pkg::DEN_W'(in_b_num);
      p_bd_r <= rau_pkg::DEN_W'(a_den_fix) * rau_pkg::DEN_W'(b_den_fix);
    end
  end

  assign ad_x = {p_ad_r[rau_pkg::DEN_W-1], p_ad_r};
  assign bc_x = {p_bc_r[rau_pkg::DEN_W-1], p_bc_r};
  assign ac_x = {p_ac_r[rau_pkg::DEN_W-1], p_ac_r};

  always_comb begin
    unique case (cmd_r)
      rau_pkg::CMD_ADD: begin
        num = ad_x + bc_x;
        den = p_bd_r;
      end
      rau_pkg::CMD_SUB: begin
        num = ad_x - bc_x;
        den = p_bd_r;
      end
      rau_pkg::CMD_MUL: begin
        num = ac_x;
        den = p_bd_r;
      end
      rau_pkg::CMD_DIV: begin
        num = ad_x;
        den = p_bc_r;
      end
      default: begin
        num = ad_x;
        den = p_bd_r;
      end
    endcase
  end

  assign den_zero        = (den == '0);
  assign push_valid      = vld_r;
  assign push_data.num   = num;
  assign push_data.den   = den_zero ? rau_pkg::DEN_W'(1) : den;
  assign push_data.fixed = fix_r || den_zero;

endmodule

`default_nettype wire

[design/rau_queue.sv]
`default_nettype none

module rau_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire rau_pkg::frac_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output rau_pkg::frac_t       pop_data
);

  rau_pkg::frac_t               mem_r [rau_pkg::QDEPTH];
  logic [rau_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [rau_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [rau_pkg::QCNT_W-1:0]   cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (cnt_r != rau_pkg::QCNT_W'(rau_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == rau_pkg::QPTR_W'(rau_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == rau_pkg::QPTR_W'(rau_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/rau_back.sv]
`default_nettype none

module rau_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               pop_valid,
  output logic                                    pop_ready,
  input  wire rau_pkg::frac_t                     pop_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]        out_res_num,
  output logic signed [rau_pkg::DEN_W-1:0]        out_res_den,
  output logic                                    out_zero_den_fixed
);

  localparam int MW = rau_pkg::MAG_W;

  rau_pkg::back_state_t          state_r;
  rau_pkg::back_state_t          state_nxt;

  logic [MW-1:0]                 x_r;
  logic [MW-1:0]                 y_r;
  logic [rau_pkg::SHIFT_W-1:0]   k_r;
  logic [MW-1:0]                 g_r;
  logic [MW-1:0]                 qn_r;
  logic [MW-1:0]                 qd_r;
  logic [MW-1:0]                 rn_r;
  logic [MW-1:0]                 rd_r;
  logic [rau_pkg::CNT_W-1:0]     cnt_r;
  logic                          neg_n_r;
  logic                          neg_d_r;
  logic                          fix_r;

  logic                          in_neg_n;
  logic                          in_neg_d;
  logic [rau_pkg::NUM_W-1:0]     mag_n_full;
  logic [rau_pkg::DEN_W-1:0]     mag_d_full;
  logic [MW-1:0]                 mag_n;
  logic [MW-1:0]                 mag_d;

  logic                          gcd_done;
  logic                          div_last;
  logic [MW-1:0]                 diff_xy;
  logic [MW-1:0]                 diff_yx;

  logic [MW:0]                   sh_n;
  logic [MW:0]                   sh_d;
  logic [MW:0]                   dif_n;
  logic [MW:0]                   dif_d;
  logic                          bit_n;
  logic                          bit_d;

  logic [rau_pkg::NUM_W-1:0]     qn_ext;
  logic [MW:0]                   qd_ext;

  assign in_neg_n   = pop_data.num[rau_pkg::NUM_W-1];
  assign in_neg_d   = pop_data.den[rau_pkg::DEN_W-1];
  assign mag_n_full = in_neg_n ? -pop_data.num : pop_data.num;
  assign mag_d_full = in_neg_d ? -pop_data.den : pop_data.den;
  assign mag_n      = mag_n_full[MW-1:0];
  assign mag_d      = rau_pkg::MAG_W'(mag_d_full);

  assign gcd_done = (x_r == '0) || (y_r == '0);
  assign div_last = (cnt_r == rau_pkg::CNT_W'(MW - 1));
  assign diff_xy  = x_r - y_r;
  assign diff_yx  = y_r - x_r;

  // one restoring division step per cycle for each part, shared divisor
  assign sh_n  = {rn_r, qn_r[MW-1]};
  assign sh_d  = {rd_r, qd_r[MW-1]};
  assign dif_n = sh_n - {1'b0, g_r};
  assign dif_d = sh_d - {1'b0, g_r};
  assign bit_n = !dif_n[MW];
  assign bit_d = !dif_d[MW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::BK_IDLE: if (pop_valid) state_nxt = rau_pkg::BK_GCD;
      rau_pkg::BK_GCD:  if (gcd_done) state_nxt = rau_pkg::BK_DIV;
      rau_pkg::BK_DIV:  if (div_last) state_nxt = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT:  if (out_ready) state_nxt = rau_pkg::BK_IDLE;
      default:          state_nxt = rau_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rau_pkg::BK_IDLE: pop_ready = 1'b1;
      rau_pkg::BK_OUT:  out_valid = 1'b1;
      default: begin
        pop_ready = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::BK_IDLE: begin
        if (pop_valid) begin
          x_r     <= mag_n;
          y_r     <= mag_d;
          qn_r    <= mag_n;
          qd_r    <= mag_d;
          k_r     <= '0;
          neg_n_r <= in_neg_n;
          neg_d_r <= in_neg_d;
          fix_r   <= pop_data.fixed;
        end
      end
      rau_pkg::BK_GCD: begin
        if (gcd_done) begin
          g_r   <= (x_r | y_r) << k_r;
          rn_r  <= '0;
          rd_r  <= '0;
          cnt_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          // common factor of two
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= diff_xy >> 1;
        end else begin
          y_r <= diff_yx >> 1;
        end
      end
      rau_pkg::BK_DIV: begin
        qn_r  <= {qn_r[MW-2:0], bit_n};
        qd_r  <= {qd_r[MW-2:0], bit_d};
        rn_r  <= bit_n ? dif_n[MW-1:0] : sh_n[MW-1:0];
        rd_r  <= bit_d ? dif_d[MW-1:0] : sh_d[MW-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign qn_ext             = rau_pkg::NUM_W'(qn_r);
  assign qd_ext             = {1'b0, qd_r};
  assign out_res_num        = neg_n_r ? -qn_ext : qn_ext;
  assign out_res_den        = rau_pkg::DEN_W'(neg_d_r ? -qd_ext : qd_ext);
  assign out_zero_den_fixed = fix_r;

endmodule

`default_nettype wire

[design/rational_arithmetic_unit_core.sv]
// rational arithmetic unit: adds, subtracts, multiplies or divides two
// signed fractions and returns the result reduced by the gcd of its parts.
// input channel: in_valid/in_ready with in_command and the four operands;
// a word is taken when both are high. result channel: out_valid/out_ready
// with out_res_num, out_res_den and out_zero_den_fixed.
// the front end registers the operand products and forms the unreduced
// fraction from them combinationally, then hands it to a two-word queue.
// the reducer takes one word at a time: it loads the word, takes one binary
// gcd step per cycle (up to about 2*MAG_W = 64 steps, fewer for small
// values), forms the divisor, then runs restoring division of both parts
// at once, one quotient bit per cycle for MAG_W = 32 bits. it takes no new
// word until its result has been taken on out_ready.
// the input side keeps taking words while the queue has room, even while a
// result waits for out_ready; a stalled result holds steady on the ports.
// reset (rst_n low, synchronous) empties the queue and the front stage and
// drops out_valid.
`default_nettype none

module rational_arithmetic_unit_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [1:0]                            in_command,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]  in_a_num,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]  in_a_den,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]  in_b_num,
  input  wire logic signed [rau_pkg::OPERAND_W-1:0]  in_b_den,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]           out_res_num,
  output logic signed [rau_pkg::DEN_W-1:0]           out_res_den,
  output logic                                       out_zero_den_fixed
);

  logic           push_valid;
  logic           push_ready;
  rau_pkg::frac_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  rau_pkg::frac_t pop_data;

  rau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rau_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_data           (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_res_num        (out_res_num),
    .out_res_den        (out_res_den),
    .out_zero_den_fixed (out_zero_den_fixed)
  );

endmodule

`default_nettype wire

[design/rau_checker.sv]
`default_nettype none

module rau_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic signed [rau_pkg::NUM_W-1:0]      out_res_num,
  input wire logic signed [rau_pkg::DEN_W-1:0]      out_res_den,
  input wire logic                                  out_zero_den_fixed
);

  // a result never leaves reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num)
      && $stable(out_res_den) && $stable(out_zero_den_fixed))
    else $error("stalled result word changed");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != '0)
    else $error("zero result denominator");

  // a zero numerator reduces to a unit denominator
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_num == '0 |->
      out_res_den == rau_pkg::DEN_W'(1) || out_res_den == '1)
    else $error("zero numerator not over unit denominator");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_res_num        (out_res_num),
  .out_res_den        (out_res_den),
  .out_zero_den_fixed (out_zero_den_fixed)
);

`default_nettype wire
